>>> rtl/cpc_pkg.sv
// ---------------------------------------------------------------------------
// cpc_pkg
// Types, constants and helper functions of the color to pixel converter.
// ---------------------------------------------------------------------------
package cpc_pkg;

   localparam int COLOR_W = 24;
   localparam int INDEX_W = 8;
   localparam int PIXEL_W = 32;
   localparam int DIST_W  = 18;
   localparam int COUNT_W = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   localparam logic [DIST_W-1:0] DIST_START = DIST_W'(3 * 256 * 256);

   localparam logic [4:0] RED_POS_RESET   = 5'd16;
   localparam logic [3:0] RED_WID_RESET   = 4'd8;
   localparam logic [4:0] GREEN_POS_RESET = 5'd8;
   localparam logic [3:0] GREEN_WID_RESET = 4'd8;
   localparam logic [4:0] BLUE_POS_RESET  = 5'd0;
   localparam logic [3:0] BLUE_WID_RESET  = 4'd8;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PIXEL_MODE     = 3'd0,
      CSR_RED_POSITION   = 3'd1,
      CSR_RED_WIDTH      = 3'd2,
      CSR_GREEN_POSITION = 3'd3,
      CSR_GREEN_WIDTH    = 3'd4,
      CSR_BLUE_POSITION  = 3'd5,
      CSR_BLUE_WIDTH     = 3'd6,
      CSR_PALETTE_COUNT  = 3'd7
   } csr_index_type;

   typedef enum logic {
      FUNC_CONVERT = 1'b0,
      FUNC_WRITE   = 1'b1
   } func_type;

   typedef enum logic {
      MODE_PACKED  = 1'b0,
      MODE_PALETTE = 1'b1
   } pixel_mode_type;

   typedef struct packed {
      pixel_mode_type     pixel_mode;
      logic [4:0]         red_position;
      logic [3:0]         red_width;
      logic [4:0]         green_position;
      logic [3:0]         green_width;
      logic [4:0]         blue_position;
      logic [3:0]         blue_width;
      logic [COUNT_W-1:0] palette_count;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      func_type           func;
      logic [COLOR_W-1:0] color;
      logic [INDEX_W-1:0] palette_index;
      logic [DIST_W-1:0]  best_dist;
      logic [INDEX_W-1:0] best_index;
   } token_type;

   function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return 16'(d) * 16'(d);
   endfunction

   function automatic logic [PIXEL_W-1:0] place_field(input logic [7:0] chan,
                                                      input logic [4:0] pos,
                                                      input logic [3:0] width);
      logic [8:0] mask;
      logic [3:0] w;
      w    = (width > 4'd8) ? 4'd8 : width;
      mask = (9'd1 << w) - 9'd1;
      return {24'd0, chan & mask[7:0]} << pos;
   endfunction

endpackage

>>> rtl/cpc_req_if.sv
// ---------------------------------------------------------------------------
// cpc_req_if
// Request channel: color conversion or palette write transactions.
// ---------------------------------------------------------------------------
interface cpc_req_if;
   import cpc_pkg::*;

   logic               valid;
   logic               ready;
   logic               func;
   logic [COLOR_W-1:0] color;
   logic [INDEX_W-1:0] palette_index;

   modport source(output valid, func, color, palette_index, input ready);
   modport sink(input valid, func, color, palette_index, output ready);
   modport monitor(input valid, ready, func, color, palette_index);
endinterface

>>> rtl/cpc_rsp_if.sv
// ---------------------------------------------------------------------------
// cpc_rsp_if
// Response channel: pixel values.
// ---------------------------------------------------------------------------
interface cpc_rsp_if;
   import cpc_pkg::*;

   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;

   modport source(output valid, pixel, input ready);
   modport sink(input valid, pixel, output ready);
   modport monitor(input valid, ready, pixel);
endinterface

>>> rtl/cpc_cell.sv
// ---------------------------------------------------------------------------
// cpc_cell
// One palette cell: holds one entry, applies writes addressed to it and
// folds its distance into the running best of a passing transaction.
// ---------------------------------------------------------------------------
module cpc_cell
   import cpc_pkg::*;
#(
   parameter int CELL_INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [COUNT_W-1:0] palette_count,
   input  token_type          tok_in,
   output token_type          tok_out
);

   logic [COLOR_W-1:0] entry_ff;
   token_type          tok_ff;
   token_type          tok_in_next;
   logic [DIST_W-1:0]  cand_dist;
   logic               active;
   logic               hit_write;

   always_comb begin
      cand_dist = DIST_W'(sq_diff(tok_in.color[23:16], entry_ff[23:16]))
                + DIST_W'(sq_diff(tok_in.color[15:8],  entry_ff[15:8]))
                + DIST_W'(sq_diff(tok_in.color[7:0],   entry_ff[7:0]));
      active    = COUNT_W'(CELL_INDEX) < palette_count;
      hit_write = tok_in.valid && (tok_in.func == FUNC_WRITE)
                  && (tok_in.palette_index == INDEX_W'(CELL_INDEX));
      tok_in_next = tok_in;
      if (tok_in.valid && (tok_in.func == FUNC_CONVERT) && active
          && (cand_dist < tok_in.best_dist)) begin
         tok_in_next.best_dist  = cand_dist;
         tok_in_next.best_index = INDEX_W'(CELL_INDEX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else if (advance) begin
         tok_ff <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && hit_write) begin
         entry_ff <= tok_in.color;
      end
   end

   assign tok_out = tok_ff;

endmodule

>>> rtl/cpc_out.sv
// ---------------------------------------------------------------------------
// cpc_out
// Output register: packs channels or forwards the chosen palette index.
// ---------------------------------------------------------------------------
module cpc_out
   import cpc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  cfg_type            cfg,
   input  token_type          tok,
   output logic               rsp_valid,
   output logic [PIXEL_W-1:0] rsp_pixel
);

   logic               valid_ff;
   logic               valid_in;
   logic [PIXEL_W-1:0] pixel_ff;
   logic [PIXEL_W-1:0] pixel_in;

   always_comb begin
      valid_in = tok.valid && (tok.func == FUNC_CONVERT);
      if (cfg.pixel_mode == MODE_PACKED) begin
         pixel_in = place_field(tok.color[23:16], cfg.red_position, cfg.red_width)
                  | place_field(tok.color[15:8], cfg.green_position, cfg.green_width)
                  | place_field(tok.color[7:0], cfg.blue_position, cfg.blue_width);
      end else begin
         pixel_in = PIXEL_W'(tok.best_index);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pixel_ff <= pixel_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_pixel = pixel_ff;

endmodule

>>> rtl/color_to_pixel_converter_core.sv
// ---------------------------------------------------------------------------
// color_to_pixel_converter_core
// Converts 24-bit RGB colors to packed or nearest-palette pixel values.
// ---------------------------------------------------------------------------
// Every request transaction travels down a chain of PALETTE_ENTRIES cells,
// one cell per cycle, and then through one output register; one
// transaction is taken per cycle, and the whole chain holds while a result
// waits. Each cell stores one palette entry and keeps the running least
// distance, so palette writes take effect in order with conversions. A
// write transaction gives no response. Palette entries must be written
// before a palette search reads them. The user must write configuration
// only while no transaction is in flight; the block does not enforce this.
// ---------------------------------------------------------------------------
module color_to_pixel_converter_core
   import cpc_pkg::*;
#(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   cpc_req_if.sink               req_if,
   cpc_rsp_if.source             rsp_if,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cfg_type   cfg_ff;
   logic      advance;
   logic      rsp_valid;
   token_type tok_head;
   token_type chain [PALETTE_ENTRIES+1];

   assign advance      = !rsp_valid || rsp_if.ready;
   assign req_if.ready = advance;
   assign rsp_if.valid = rsp_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_mode     <= MODE_PACKED;
         cfg_ff.red_position   <= RED_POS_RESET;
         cfg_ff.red_width      <= RED_WID_RESET;
         cfg_ff.green_position <= GREEN_POS_RESET;
         cfg_ff.green_width    <= GREEN_WID_RESET;
         cfg_ff.blue_position  <= BLUE_POS_RESET;
         cfg_ff.blue_width     <= BLUE_WID_RESET;
         cfg_ff.palette_count  <= COUNT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_PIXEL_MODE:     cfg_ff.pixel_mode     <= pixel_mode_type'(csr_write_data[0]);
            CSR_RED_POSITION:   cfg_ff.red_position   <= csr_write_data[4:0];
            CSR_RED_WIDTH:      cfg_ff.red_width      <= csr_write_data[3:0];
            CSR_GREEN_POSITION: cfg_ff.green_position <= csr_write_data[4:0];
            CSR_GREEN_WIDTH:    cfg_ff.green_width    <= csr_write_data[3:0];
            CSR_BLUE_POSITION:  cfg_ff.blue_position  <= csr_write_data[4:0];
            CSR_BLUE_WIDTH:     cfg_ff.blue_width     <= csr_write_data[3:0];
            CSR_PALETTE_COUNT:  cfg_ff.palette_count  <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      tok_head.valid         = req_if.valid;
      tok_head.func          = func_type'(req_if.func);
      tok_head.color         = req_if.color;
      tok_head.palette_index = req_if.palette_index;
      tok_head.best_dist     = DIST_START;
      tok_head.best_index    = '0;
   end

   assign chain[0] = tok_head;

   for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
      cpc_cell #(
         .CELL_INDEX (i)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .advance       (advance),
         .palette_count (cfg_ff.palette_count),
         .tok_in        (chain[i]),
         .tok_out       (chain[i+1])
      );
   end

   cpc_out u_out (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg_ff),
      .tok       (chain[PALETTE_ENTRIES]),
      .rsp_valid (rsp_valid),
      .rsp_pixel (rsp_if.pixel)
   );

endmodule

>>> rtl/cpc_checker.sv
// ---------------------------------------------------------------------------
// cpc_checker
// Port-level checks of the color to pixel converter.
// ---------------------------------------------------------------------------
module cpc_checker
   import cpc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [PIXEL_W-1:0] rsp_pixel
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pixel))
      else $error("response pixel changed while stalled");

   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow response backpressure");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind color_to_pixel_converter_core cpc_checker u_cpc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_pixel (rsp_if.pixel)
);
